>>> rtl/core/lnc_pkg.sv
// Shared types and constants of the LFSR noise channel.
package lnc_pkg;

  localparam int unsigned LFSR_W = 15;
  localparam int unsigned ENV_W = 16;
  localparam int unsigned VOL_W = 17;
  localparam int unsigned INC_W = 20;
  localparam int unsigned SAMPLE_W = 15;
  localparam int unsigned PROD_W = ENV_W + VOL_W;
  localparam int unsigned MAG_SHIFT = 19;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DATA_W = INC_W;

  localparam logic [VOL_W-1:0] VOL_MAX = 17'd65536;
  localparam logic [INC_W-1:0] INC_RESET = 20'd5944;
  localparam logic [VOL_W-1:0] VOL_RESET = 17'd32768;
  localparam logic [LFSR_W-1:0] LFSR_SEED = 15'd1;

  localparam int unsigned TAP_LONG = 1;
  localparam int unsigned TAP_SHORT = 6;

  // Register indexes of the configuration port.
  localparam logic [CFG_IDX_W-1:0] CFG_CLOCK_INCREMENT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_VOLUME = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SHORT_MODE = 2'd2;

  typedef struct packed {
    logic req_type;
    logic [ENV_W-1:0] env_level;
    logic env_idle;
  } in_item_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic noise_bit;
    logic voice_active;
  } out_item_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SHIFT,
    ST_MULT,
    ST_DONE
  } state_e;

endpackage

>>> rtl/core/lnc_lfsr_step.sv
// One shift of the 15-bit noise LFSR with tap select and zero recovery.
module lnc_lfsr_step (
  input  logic [lnc_pkg::LFSR_W-1:0] lfsr_i,
  input  logic                       short_mode_i,
  output logic [lnc_pkg::LFSR_W-1:0] lfsr_o
);

  logic                       tap;
  logic [lnc_pkg::LFSR_W-1:0] shifted;

  always_comb begin
    tap = short_mode_i ? lfsr_i[lnc_pkg::TAP_SHORT] : lfsr_i[lnc_pkg::TAP_LONG];
    shifted = {lfsr_i[0] ^ tap, lfsr_i[lnc_pkg::LFSR_W-1:1]};
    // Force a dead register back to the seed.
    lfsr_o = (shifted == '0) ? lnc_pkg::LFSR_SEED : shifted;
  end

endmodule

>>> rtl/core/lfsr_noise_channel_core.sv
// Top level of the LFSR noise channel: sequencer, phase timer, gain multiply and output register.
// Note start: taken without leaving idle, gives no result; the block is ready again next cycle.
// Active tick: SHIFT takes n LFSR steps and a loop exit, MULT multiplies, DONE registers the result
//   once the output register is free, then back to IDLE; n = min(whole phase units, MAX_SHIFTS).
// Inactive or envelope-idle tick: straight to DONE, which registers a silent result, then back to IDLE.
// One item at a time; the output register lets the next item in while a result waits.
// Reset: LFSR = 1, phase and voice cleared, registers at defaults; no clearing pass.
module lfsr_noise_channel_core #(
  parameter int unsigned FRAC_BITS = 16,
  parameter int unsigned MAX_SHIFTS = 16
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  lnc_pkg::in_item_t              in_data_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output lnc_pkg::out_item_t             out_data_o,
  input  logic                           cfg_we_i,
  input  logic [lnc_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [lnc_pkg::CFG_DATA_W-1:0] cfg_data_i
);

  // Phase sum is wide enough for the fraction plus the increment and a carry.
  localparam int unsigned SUM_W =
    ((FRAC_BITS > lnc_pkg::INC_W) ? FRAC_BITS : lnc_pkg::INC_W) + 1;
  localparam int unsigned WHOLE_W = SUM_W - FRAC_BITS;
  localparam int unsigned CNT_W = $clog2(MAX_SHIFTS + 1);
  localparam int unsigned CMP_W = (WHOLE_W > CNT_W) ? WHOLE_W : CNT_W;

  // Configuration registers.
  logic [lnc_pkg::INC_W-1:0] inc_q;
  logic [lnc_pkg::VOL_W-1:0] vol_q;
  logic                      short_q;

  // Voice state.
  logic [lnc_pkg::LFSR_W-1:0] lfsr_q, lfsr_d;
  logic [FRAC_BITS-1:0]       frac_q, frac_d;
  logic                       voice_q, voice_d;

  // Sequencer and working registers.
  lnc_pkg::state_e            state_q, state_d;
  logic [CNT_W-1:0]           cnt_q, cnt_d;
  logic [lnc_pkg::ENV_W-1:0]  env_q, env_d;
  logic [lnc_pkg::PROD_W-1:0] prod_q, prod_d;

  // Output register.
  logic               out_valid_q, out_valid_d;
  lnc_pkg::out_item_t out_q, out_d;

  logic [lnc_pkg::LFSR_W-1:0]   lfsr_next;
  logic [SUM_W-1:0]             sum;
  logic [CMP_W-1:0]             whole;
  logic [lnc_pkg::SAMPLE_W-1:0] mag;
  logic                         in_take;
  logic [lnc_pkg::VOL_W-1:0]    cfg_vol;

  lnc_lfsr_step u_step (
    .lfsr_i       (lfsr_q),
    .short_mode_i (short_q),
    .lfsr_o       (lfsr_next)
  );

  assign in_stall_o = (state_q != lnc_pkg::ST_IDLE);
  assign in_take = in_valid_i && !in_stall_o;
  assign out_valid_o = out_valid_q;
  assign out_data_o = out_q;

  // Advance the phase: whole units become shifts, the fraction stays.
  assign sum = SUM_W'(frac_q) + SUM_W'(inc_q);
  assign whole = CMP_W'(sum[SUM_W-1:FRAC_BITS]);
  assign mag = lnc_pkg::SAMPLE_W'(prod_q >> lnc_pkg::MAG_SHIFT);

  // Saturate the volume as it is written.
  assign cfg_vol = (cfg_data_i[lnc_pkg::VOL_W-1:0] > lnc_pkg::VOL_MAX) ?
                   lnc_pkg::VOL_MAX : cfg_data_i[lnc_pkg::VOL_W-1:0];

  always_comb begin
    state_d = state_q;
    lfsr_d = lfsr_q;
    frac_d = frac_q;
    voice_d = voice_q;
    cnt_d = cnt_q;
    env_d = env_q;
    prod_d = prod_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_d = out_q;

    unique case (state_q)
      lnc_pkg::ST_IDLE: begin
        if (in_take) begin
          if (in_data_i.req_type) begin
            // Note start: reseed, clear the phase, turn the voice on.
            lfsr_d = lnc_pkg::LFSR_SEED;
            frac_d = '0;
            voice_d = 1'b1;
          end else if (voice_q && !in_data_i.env_idle) begin
            frac_d = sum[FRAC_BITS-1:0];
            cnt_d = (whole > CMP_W'(MAX_SHIFTS)) ? CNT_W'(MAX_SHIFTS) : CNT_W'(whole);
            env_d = in_data_i.env_level;
            state_d = lnc_pkg::ST_SHIFT;
          end else begin
            // Inactive voice or idle envelope: drop the voice, report silence.
            voice_d = 1'b0;
            state_d = lnc_pkg::ST_DONE;
          end
        end
      end
      lnc_pkg::ST_SHIFT: begin
        if (cnt_q == '0) begin
          state_d = lnc_pkg::ST_MULT;
        end else begin
          lfsr_d = lfsr_next;
          cnt_d = cnt_q - CNT_W'(1);
        end
      end
      lnc_pkg::ST_MULT: begin
        prod_d = lnc_pkg::PROD_W'(env_q) * lnc_pkg::PROD_W'(vol_q);
        state_d = lnc_pkg::ST_DONE;
      end
      lnc_pkg::ST_DONE: begin
        // Hold the result until the output register is free.
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d = 1'b1;
          out_d.noise_bit = lfsr_q[0];
          out_d.voice_active = voice_q;
          if (!voice_q) begin
            out_d.sample = '0;
          end else if (lfsr_q[0]) begin
            out_d.sample = mag;
          end else begin
            out_d.sample = -mag;
          end
          state_d = lnc_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = lnc_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= lnc_pkg::ST_IDLE;
      lfsr_q <= lnc_pkg::LFSR_SEED;
      frac_q <= '0;
      voice_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      lfsr_q <= lfsr_d;
      frac_q <= frac_d;
      voice_q <= voice_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cnt_q <= cnt_d;
    env_q <= env_d;
    prod_q <= prod_d;
    out_q <= out_d;
  end

  // Configuration writes; indexes beyond the list are ignored.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inc_q <= lnc_pkg::INC_RESET;
      vol_q <= lnc_pkg::VOL_RESET;
      short_q <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        lnc_pkg::CFG_CLOCK_INCREMENT: inc_q <= cfg_data_i[lnc_pkg::INC_W-1:0];
        lnc_pkg::CFG_VOLUME:          vol_q <= cfg_vol;
        lnc_pkg::CFG_SHORT_MODE:      short_q <= cfg_data_i[0];
        default: begin
        end
      endcase
    end
  end

endmodule
